// ----- rtl/core/nnod_pkg.sv -----
// Shared constants, codes and helpers for the nearest-name suggester.
package nnod_pkg;

  localparam int MAX_NAME_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int CH_W     = 8;
  localparam int ID_W     = 6;
  localparam int DIST_W   = 6;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int FULL_W   = 8;
  localparam int BEST_W   = 7;

  localparam logic [BEST_W-1:0] NO_BEST = 7'd99;
  localparam logic [FULL_W-1:0] FULL_MAX = 8'd255;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_START    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TOK_CHAR = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CND_CHAR = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CND_END  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FINISH   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DIST  = 2'd2;

  localparam logic [CFG_W-1:0] SHORT_LEN_RST  = 6'd4;
  localparam logic [CFG_W-1:0] SHORT_DIST_RST = 6'd1;
  localparam logic [CFG_W-1:0] LONG_DIST_RST  = 6'd2;

  // result kinds
  localparam logic KIND_CAND  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // ASCII upper case folds to lower case, everything else passes
  function automatic logic [CH_W-1:0] fold_char(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/nnod_if.sv -----
// Query and result channel interfaces.
interface nnod_query_if;
  import nnod_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CH_W-1:0]     ch;
  logic [ID_W-1:0]     cand_id;

  modport source (output valid, action, ch, cand_id, input ready);
  modport sink   (input valid, action, ch, cand_id, output ready);
endinterface

interface nnod_result_if;
  import nnod_pkg::*;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [DIST_W-1:0] distance;
  logic              found;
  logic [ID_W-1:0]   best_id;

  modport source (output valid, result_kind, distance, found, best_id, input ready);
  modport sink   (input valid, result_kind, distance, found, best_id, output ready);
endinterface

// ----- rtl/core/nearest_name_osa_distance.sv -----
// Nearest-name suggester top level: token store, OSA column walker, best tracking.
// Start, token char and finish are handled in idle; a candidate end reads the column memory
//   (one column memory read) and loads its result from S_END; a candidate char walks the stored token.
// Throughput: one cell per cycle through the single shared cell unit, so a candidate
//   char ties the block up while its column is walked; no new query is taken until idle.
// Reset: synchronous, active high; clears control and query state, no memory clearing pass.
module nearest_name_osa_distance #(
  parameter int MAX_NAME = nnod_pkg::MAX_NAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  nnod_query_if.sink                      query,
  nnod_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [nnod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnod_pkg::CFG_W-1:0]      cfg_data
);
  import nnod_pkg::*;

  // cell values and column indexes span 0..MAX_NAME
  localparam int CW  = $clog2(MAX_NAME + 1);
  localparam int TAW = $clog2(MAX_NAME);
  localparam int NBANK = 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_NAME);

  // configuration
  logic [CFG_W-1:0] short_len_limit, short_max_dist, long_max_dist;

  // query state
  logic [1:0]        state;
  logic [CW-1:0]     stored_len;
  logic [FULL_W-1:0] full_len;
  logic [CW-1:0]     cand_len;
  logic [CH_W-1:0]   last_ch;
  logic [CH_W-1:0]   cb;
  logic [ID_W-1:0]   end_id;
  logic [BEST_W-1:0] best_dist;
  logic [ID_W-1:0]   best_cand;
  logic              have_best;

  // column banks rotate roles: previous column, the one before it, and the one being built
  logic [1:0] prev_b, pp_b, free_b;

  // column walker: issue stage (memory addresses) and compute stage (cell unit)
  logic          iss_active;
  logic [CW-1:0] iss_i;
  logic          cmp_valid;
  logic [CW-1:0] cmp_i;
  logic [CW-1:0] left;      // col[i-1]
  logic [CW-1:0] diag;      // prev[i-1]
  logic [CH_W-1:0] tok_last; // token[i-2]

  // result register
  logic              res_valid;
  logic              res_kind;
  logic [DIST_W-1:0] res_dist;
  logic              res_found;
  logic [ID_W-1:0]   res_id;
  logic              res_load;   // a new result beat is loaded this cycle

  logic accept;
  logic [CH_W-1:0] ch_fold;
  assign query.ready = (state == S_IDLE) && (!res_valid || result.ready);
  assign accept  = query.valid && query.ready;
  assign ch_fold = fold_char(query.ch);
  assign res_load = (state == S_END) || (accept && (query.action == ACT_FINISH));

  // ---------------- token store ----------------
  logic            tok_we;
  logic [CH_W-1:0] tok_rd;

  assign tok_we = accept && (query.action == ACT_TOK_CHAR) && (stored_len < LEN_MAX);

  nnod_ram #(.W(CH_W), .DEPTH(MAX_NAME)) u_tok (
    .clk   (clk),
    .we    (tok_we),
    .waddr (stored_len[TAW-1:0]),
    .wdata (ch_fold),
    .raddr (TAW'(iss_i - 1'b1)),
    .rdata (tok_rd)
  );

  // ---------------- column banks ----------------
  logic [CW-1:0] prev_addr, pp_addr;
  logic [CW-1:0] bank_rd [NBANK];
  logic [CW-1:0] prev_rd, pp_rd;
  logic [CW-1:0] cell_val;

  // in idle the prev bank is pointed at the token end, for a candidate end read
  assign prev_addr = (state == S_CALC) ? iss_i : stored_len;
  assign pp_addr   = iss_i - CW'(2);

  for (genvar k = 0; k < NBANK; k++) begin : g_bank
    nnod_ram #(.W(CW), .DEPTH(MAX_NAME + 1)) u_col (
      .clk   (clk),
      .we    (cmp_valid && (free_b == 2'(k))),
      .waddr (cmp_i),
      .wdata (cell_val),
      .raddr ((prev_b == 2'(k)) ? prev_addr : pp_addr),
      .rdata (bank_rd[k])
    );
  end

  assign prev_rd = bank_rd[prev_b];
  assign pp_rd   = bank_rd[pp_b];

  // ---------------- cell unit operands ----------------
  // Columns not yet built read as the row index; cell 0 of any column is its column number.
  logic [CW-1:0] up_val, pp_val;
  logic          match, swap;

  always_comb begin
    up_val = (cand_len == '0) ? cmp_i : prev_rd;
    if (cmp_i == CW'(2)) begin
      pp_val = cand_len - 1'b1;
    end else if (cand_len == CW'(1)) begin
      pp_val = cmp_i - CW'(2);
    end else begin
      pp_val = pp_rd;
    end
    match = (tok_rd == cb);
    swap  = (cmp_i > CW'(1)) && (cand_len != '0) && (tok_rd == last_ch) && (tok_last == cb);
  end

  nnod_cell #(.CW(CW)) u_cell (
    .up       (up_val),
    .left     (left),
    .diag     (diag),
    .swap_src (pp_val),
    .match    (match),
    .swap     (swap),
    .val      (cell_val)
  );

  // ---------------- candidate end distance ----------------
  logic [CW-1:0]     end_d;
  logic [CFG_W-1:0]  thresh;
  logic              ok;

  always_comb begin
    if (stored_len == '0) begin
      end_d = cand_len;
    end else if (cand_len == '0) begin
      end_d = stored_len;
    end else begin
      end_d = prev_rd;
    end
    thresh = (full_len <= FULL_W'(short_len_limit)) ? short_max_dist : long_max_dist;
    ok = have_best && (full_len != '0) && (best_dist != '0) &&
         (best_dist <= BEST_W'(thresh));
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      short_len_limit <= SHORT_LEN_RST;
      short_max_dist  <= SHORT_DIST_RST;
      long_max_dist   <= LONG_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_LEN:  short_len_limit <= cfg_data;
        CFG_SHORT_DIST: short_max_dist  <= cfg_data;
        CFG_LONG_DIST:  long_max_dist   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stored_len <= '0;
      full_len   <= '0;
      cand_len   <= '0;
      last_ch    <= '0;
      best_dist  <= NO_BEST;
      best_cand  <= '0;
      have_best  <= 1'b0;
      prev_b     <= 2'd0;
      pp_b       <= 2'd1;
      free_b     <= 2'd2;
      iss_active <= 1'b0;
      cmp_valid  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (result.valid && result.ready && !res_load) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (query.action)
              ACT_START: begin
                stored_len <= '0;
                full_len   <= '0;
                cand_len   <= '0;
                last_ch    <= '0;
                best_dist  <= NO_BEST;
                best_cand  <= '0;
                have_best  <= 1'b0;
              end
              ACT_TOK_CHAR: begin
                if (stored_len < LEN_MAX) begin
                  stored_len <= stored_len + 1'b1;
                end
                if (full_len != FULL_MAX) begin
                  full_len <= full_len + 1'b1;
                end
                // any partial candidate restarts
                cand_len <= '0;
                last_ch  <= '0;
              end
              ACT_CND_CHAR: begin
                if (cand_len < LEN_MAX) begin
                  if (stored_len == '0) begin
                    cand_len <= cand_len + 1'b1;
                    last_ch  <= ch_fold;
                  end else begin
                    cb         <= ch_fold;
                    iss_active <= 1'b1;
                    iss_i      <= CW'(1);
                    left       <= cand_len + 1'b1;
                    diag       <= cand_len;
                    state      <= S_CALC;
                  end
                end
              end
              ACT_CND_END: begin
                end_id <= query.cand_id;
                state  <= S_END;
              end
              ACT_FINISH: begin
                res_valid <= 1'b1;
                res_kind  <= KIND_FINAL;
                res_dist  <= have_best ? best_dist[DIST_W-1:0] : '0;
                res_found <= ok;
                res_id    <= ok ? best_cand : '0;
              end
              default: ;
            endcase
          end
        end

        S_CALC: begin
          // issue stage; it has stopped by the time the last cell is computed
          cmp_valid <= iss_active;
          cmp_i     <= iss_i;
          if (iss_active) begin
            if (iss_i == stored_len) begin
              iss_active <= 1'b0;
            end else begin
              iss_i <= iss_i + 1'b1;
            end
          end
          // compute stage
          if (cmp_valid) begin
            left     <= cell_val;
            diag     <= up_val;
            tok_last <= tok_rd;
            if (cmp_i == stored_len) begin
              pp_b      <= prev_b;
              prev_b    <= free_b;
              free_b    <= pp_b;
              cand_len  <= cand_len + 1'b1;
              last_ch   <= cb;
              state     <= S_IDLE;
            end
          end
        end

        S_END: begin
          if (BEST_W'(end_d) < best_dist) begin
            best_dist <= BEST_W'(end_d);
            best_cand <= end_id;
            have_best <= 1'b1;
          end
          cand_len  <= '0;
          last_ch   <= '0;
          res_valid <= 1'b1;
          res_kind  <= KIND_CAND;
          res_dist  <= DIST_W'(end_d);
          res_found <= 1'b0;
          res_id    <= end_id;
          state     <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid       = res_valid;
  assign result.result_kind = res_kind;
  assign result.distance    = res_dist;
  assign result.found       = res_found;
  assign result.best_id     = res_id;

`ifndef NO_ASSERTIONS
  // column banks always hold three distinct roles
  a_bank_roles: assert property (@(posedge clk) disable iff (rst)
    (prev_b != pp_b) && (prev_b != free_b) && (pp_b != free_b))
    else $error("column bank roles collide");

  // the cell unit only runs while walking a column
  a_cmp_in_calc: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_CALC))
    else $error("cell compute outside column walk");

  // a suggestion is never an exact match
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.found) |-> (result.distance != '0))
    else $error("suggestion with zero distance");

  // candidate and token lengths never pass MAX_NAME
  a_cand_len: assert property (@(posedge clk) disable iff (rst)
    (cand_len <= LEN_MAX) && (stored_len <= LEN_MAX))
    else $error("length counter overflow");

  // a candidate end result follows its read cycle
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_END) |=> (res_valid && (res_kind == KIND_CAND)))
    else $error("candidate end result missing");
`endif

endmodule

// ----- rtl/core/nnod_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nnod_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/nnod_cell.sv -----
// One OSA cell: min of insert, delete, substitute and adjacent swap.
module nnod_cell #(
  parameter int CW = 6
) (
  input  logic [CW-1:0] up,
  input  logic [CW-1:0] left,
  input  logic [CW-1:0] diag,
  input  logic [CW-1:0] swap_src,
  input  logic          match,
  input  logic          swap,
  output logic [CW-1:0] val
);
  logic [CW:0] a, b, c, s, m1, m2;

  always_comb begin
    a  = {1'b0, up} + 1'b1;
    b  = {1'b0, left} + 1'b1;
    c  = {1'b0, diag} + {{CW{1'b0}}, ~match};
    s  = {1'b0, swap_src} + 1'b1;
    m1 = (a < b) ? a : b;
    m2 = (m1 < c) ? m1 : c;
    if (swap && s < m2) begin
      m2 = s;
    end
    val = m2[CW-1:0];
  end
endmodule
